>>> rtl/trw_pkg.sv
// shared types and constants for the timestamp reorder window
`timescale 1ns / 1ps
package trw_pkg;

	localparam int TIME_W = 63;
	localparam int TAG_W = 16;
	localparam int WIN_W = 6;
	localparam logic [WIN_W-1:0] WINDOW_RESET = 6'd20;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic              command;
		logic [TIME_W-1:0] event_time;
		logic [TAG_W-1:0]  message_tag;
	} in_item_t;

	typedef struct packed {
		logic              emitted;
		logic [TIME_W-1:0] out_time;
		logic [TAG_W-1:0]  out_tag;
		logic              window_too_small;
		logic              arrival_disorder;
		logic              last;
	} out_item_t;

	// what every cell of the sorted row does this cycle
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

endpackage

>>> rtl/trw_cell.sv
// one slot of the sorted row: insert by local compare, shift toward the head on pop
`timescale 1ns / 1ps
module trw_cell import trw_pkg::*; #(
	parameter int IDX = 0,
	parameter int CNT_W = 6,
	parameter int STW = 16
) (
	input  logic              clk,
	input  cell_ctl_t         ctl,
	input  logic [CNT_W-1:0]  count,
	input  logic [TIME_W-1:0] new_time,
	input  logic [STW-1:0]    new_tag,
	input  logic              left_ge,
	input  logic [TIME_W-1:0] left_time,
	input  logic [STW-1:0]    left_tag,
	input  logic [TIME_W-1:0] right_post_time,
	input  logic [STW-1:0]    right_post_tag,
	output logic              ge,
	output logic [TIME_W-1:0] time_q,
	output logic [STW-1:0]    tag_q,
	output logic [TIME_W-1:0] post_time,
	output logic [STW-1:0]    post_tag
);

	logic occ;

	assign occ = CNT_W'(IDX) < count;
	// at or after the insertion point: empty, or strictly later than the new event
	assign ge = !occ || (time_q > new_time);

	always_comb begin
		if (ctl.push && left_ge) begin
			post_time = left_time;
			post_tag = left_tag;
		end else if (ctl.push && ge) begin
			post_time = new_time;
			post_tag = new_tag;
		end else begin
			post_time = time_q;
			post_tag = tag_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			time_q <= right_post_time;
			tag_q <= right_post_tag;
		end else begin
			time_q <= post_time;
			tag_q <= post_tag;
		end
	end

endmodule

>>> rtl/timestamp_reorder_window.sv
// top level: sliding window reorder buffer for timestamped events
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall   in_item_t: command, event_time, message_tag
//   out      output     out_valid/out_stall out_item_t: emitted .. last
//   cfg      input      cfg_valid/cfg_ready window_size, 6 bits
//
// a push gives one result; pushes can follow back to back while the output is not held
// a flush stalls the input and gives one result per cycle while the output is not held, held
// count or one if empty, set by the cell row moving one entry toward the head per cycle
// reset clears the count, both previous timestamps and the output register
// out_stall holds the output register, and the input stalls while it is full and held
`timescale 1ns / 1ps
module timestamp_reorder_window import trw_pkg::*; #(
	parameter int MAX_WINDOW = 32,
	parameter int TAG_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [WIN_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = CNT_W + WIN_W;
	localparam int STW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

	typedef enum logic {ST_RUN, ST_FLUSH} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [WIN_W-1:0]  window_q;
	logic [TIME_W-1:0] prev_arrival_q;
	logic [TIME_W-1:0] prev_emit_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              out_free;
	logic              in_fire;
	logic              push;
	logic              push_pop;
	logic              flush_pop;
	logic [CMP_W-1:0]  win_ext;
	logic [CMP_W-1:0]  eff_win;
	logic [CMP_W-1:0]  count_next;
	cell_ctl_t         ctl;
	logic [TIME_W-1:0] new_time;
	logic [STW-1:0]    new_tag;

	logic              ge      [MAX_WINDOW];
	logic [TIME_W-1:0] st_time [MAX_WINDOW];
	logic [STW-1:0]    st_tag  [MAX_WINDOW];
	logic [TIME_W-1:0] pt_time [MAX_WINDOW];
	logic [STW-1:0]    pt_tag  [MAX_WINDOW];

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_RUN) || !out_free;
	assign in_fire = in_valid && !in_stall;
	assign push = in_fire && (in_data.command == CMD_PUSH);

	assign new_time = in_data.event_time;
	assign new_tag = in_data.message_tag[STW-1:0];

	// window clamped to one .. MAX_WINDOW
	assign win_ext = CMP_W'(window_q);
	always_comb begin
		if (window_q == '0) begin
			eff_win = CMP_W'(1);
		end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
			eff_win = CMP_W'(MAX_WINDOW);
		end else begin
			eff_win = win_ext;
		end
	end

	assign count_next = CMP_W'(count_q) + CMP_W'(1);
	assign push_pop = push && (count_next >= eff_win);
	assign flush_pop = (state_q == ST_FLUSH) && out_free && (count_q != '0);
	assign ctl.push = push;
	assign ctl.pop = push_pop || flush_pop;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic              l_ge;
		logic [TIME_W-1:0] l_time;
		logic [STW-1:0]    l_tag;
		logic [TIME_W-1:0] r_time;
		logic [STW-1:0]    r_tag;

		if (i == 0) begin : g_head
			assign l_ge = 1'b0;
			assign l_time = new_time;
			assign l_tag = new_tag;
		end else begin : g_body
			assign l_ge = ge[i-1];
			assign l_time = st_time[i-1];
			assign l_tag = st_tag[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_tail
			assign r_time = pt_time[i];
			assign r_tag = pt_tag[i];
		end else begin : g_mid
			assign r_time = pt_time[i+1];
			assign r_tag = pt_tag[i+1];
		end

		trw_cell #(
			.IDX   (i),
			.CNT_W (CNT_W),
			.STW   (STW)
		) u_cell (
			.clk             (clk),
			.ctl             (ctl),
			.count           (count_q),
			.new_time        (new_time),
			.new_tag         (new_tag),
			.left_ge         (l_ge),
			.left_time       (l_time),
			.left_tag        (l_tag),
			.right_post_time (r_time),
			.right_post_tag  (r_tag),
			.ge              (ge[i]),
			.time_q          (st_time[i]),
			.tag_q           (st_tag[i]),
			.post_time       (pt_time[i]),
			.post_tag        (pt_tag[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			window_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			count_q <= '0;
			prev_arrival_q <= '0;
			prev_emit_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (push) begin
						out_valid_q <= 1'b1;
						out_q.emitted <= push_pop;
						out_q.out_time <= push_pop ? pt_time[0] : '0;
						out_q.out_tag <= push_pop ? TAG_W'(pt_tag[0]) : '0;
						out_q.window_too_small <= push_pop && (pt_time[0] < prev_emit_q);
						out_q.arrival_disorder <= new_time < prev_arrival_q;
						out_q.last <= 1'b1;
						prev_arrival_q <= new_time;
						if (push_pop) begin
							prev_emit_q <= pt_time[0];
						end else begin
							count_q <= count_next[CNT_W-1:0];
						end
					end else begin
						if (in_fire) begin
							state_q <= ST_FLUSH;
						end
						if (out_valid_q && !out_stall) begin
							out_valid_q <= 1'b0;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_q.arrival_disorder <= 1'b0;
						if (count_q == '0) begin
							// empty flush: one blank result
							out_q.emitted <= 1'b0;
							out_q.out_time <= '0;
							out_q.out_tag <= '0;
							out_q.window_too_small <= 1'b0;
							out_q.last <= 1'b1;
						end else begin
							out_q.emitted <= 1'b1;
							out_q.out_time <= pt_time[0];
							out_q.out_tag <= TAG_W'(pt_tag[0]);
							out_q.window_too_small <= pt_time[0] < prev_emit_q;
							out_q.last <= count_q == CNT_W'(1);
							count_q <= count_q - CNT_W'(1);
						end
						if (count_q <= CNT_W'(1)) begin
							state_q <= ST_RUN;
							prev_arrival_q <= '0;
							prev_emit_q <= '0;
						end else begin
							prev_emit_q <= pt_time[0];
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// the row never fills: a push at MAX_WINDOW - 1 always pops
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CNT_W'(MAX_WINDOW))
		else $error("held count reached the row length");

	a_flush_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> in_stall)
		else $error("input not stalled during flush");

	a_push_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (out_valid && out_data.last && (state_q == ST_RUN)))
		else $error("push transfer did not leave a final result");

	a_flush_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |=> (count_q <= $past(count_q)))
		else $error("held count grew during flush");

endmodule
